@@ rtl/dynamic_array_shift_erase_unit_defines.svh @@
// Assertion macros shared by the dynamic array shift-erase unit.
`ifndef DYNAMIC_ARRAY_SHIFT_ERASE_UNIT_DEFINES_SVH
`define DYNAMIC_ARRAY_SHIFT_ERASE_UNIT_DEFINES_SVH
`ifndef ASSERT_OFF
// Clocked check, masked while reset is high.
`define DASE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Clocked check that also runs across reset.
`define DASE_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define DASE_ASSERT(lbl, prop, msg)
`define DASE_ASSERT_RST(lbl, prop, msg)
`endif
`endif

@@ rtl/dase_pkg.sv @@
// Shared widths, command codes and error codes for the shift-erase array.
package dase_pkg;

  localparam int WORD_W = 32;
  localparam int CMD_W  = 3;
  localparam int IDX_W  = 10;
  localparam int SIZE_W = 11;
  localparam int ERR_W  = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_APPEND = 3'd0,
    CMD_SET    = 3'd1,
    CMD_ERASE  = 3'd2,
    CMD_GET    = 3'd3,
    CMD_STATUS = 3'd4
  } cmd_t;

  typedef enum logic [ERR_W-1:0] {
    ERR_OK    = 2'd0,
    ERR_RANGE = 2'd1,
    ERR_FULL  = 2'd2
  } err_t;

endpackage

@@ rtl/dase_cell.sv @@
// One word cell of the circulating storage ring.
module dase_cell
  import dase_pkg::*;
(
  input  logic              clk,
  input  logic              shift,
  input  logic [WORD_W-1:0] d,
  output logic [WORD_W-1:0] q
);

  // take the input word (neighbor's or feedback) on every rotation step
  always_ff @(posedge clk) begin
    if (shift) begin
      q <= d;
    end
  end

endmodule

@@ rtl/dase_ctrl.sv @@
// Command sequencer: size/capacity tracking, ring rotation and result register.
`include "dynamic_array_shift_erase_unit_defines.svh"
module dase_ctrl
  import dase_pkg::*;
#(
  parameter int DEPTH            = 1024,
  parameter int INITIAL_CAPACITY = 10
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [CMD_W-1:0]         cmd,
  input  logic [IDX_W-1:0]         index,
  input  logic [WORD_W-1:0]        value,
  input  logic [WORD_W-1:0]        tap0,
  input  logic [WORD_W-1:0]        tap1,
  output logic                     ring_shift,
  output logic [WORD_W-1:0]        ring_fb,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [WORD_W-1:0]        read_value,
  output logic [SIZE_W-1:0]        size_now,
  output logic [SIZE_W-1:0]        capacity_now,
  output logic [ERR_W-1:0]         error
);

  localparam int AW     = $clog2(DEPTH);
  localparam int CNT_RAW = $clog2(DEPTH + 1);
  localparam int CNT_W  = (CNT_RAW > SIZE_W) ? CNT_RAW : SIZE_W;
  localparam int CAP_RAW = $clog2(2 * DEPTH + INITIAL_CAPACITY + 1);
  localparam int CAP_W  = (CAP_RAW > SIZE_W) ? CAP_RAW : SIZE_W;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SEEK  = 4'b0010,
    ST_ERASE = 4'b0100,
    ST_FIN   = 4'b1000
  } state_t;

  state_t             state, state_next;
  logic [CNT_W-1:0]   count, count_next;
  logic [CAP_W-1:0]   cap, cap_next;
  logic [AW-1:0]      head, head_next;
  logic               out_valid_next;
  logic               load_out;

  // latched command
  cmd_t               op;
  logic [WORD_W-1:0]  word;
  logic [AW-1:0]      target;
  logic [WORD_W-1:0]  rd;
  err_t               err;

  // accept-time decode
  logic [CNT_W-1:0]   idx_c;
  logic [CNT_W-1:0]   cnt_m1;
  logic [AW-1:0]      last;
  err_t               acc_err;
  logic               acc_seek;
  logic [AW-1:0]      acc_target;
  logic               at_target;
  logic               at_last;

  assign idx_c     = CNT_W'(index);
  assign cnt_m1    = count - 1'b1;
  assign last      = cnt_m1[AW-1:0];
  assign at_target = (head == target);
  assign at_last   = (head == last);
  assign in_ready  = (state == ST_IDLE);

  // range and full checks on the incoming command
  always_comb begin
    acc_err    = ERR_OK;
    acc_seek   = 1'b0;
    acc_target = idx_c[AW-1:0];
    case (cmd)
      CMD_APPEND: begin
        if (count == CNT_W'(DEPTH)) begin
          acc_err = ERR_FULL;
        end else begin
          acc_seek   = 1'b1;
          acc_target = count[AW-1:0];
        end
      end
      CMD_SET, CMD_ERASE, CMD_GET: begin
        if (idx_c >= count) begin
          acc_err = ERR_RANGE;
        end else begin
          acc_seek = 1'b1;
        end
      end
      default: begin
        acc_err = ERR_OK;
      end
    endcase
  end

  // sequencer: rotate ring to the slot, then write, read or close the gap
  always_comb begin
    state_next = state;
    count_next = count;
    cap_next   = cap;
    ring_shift = 1'b0;
    ring_fb    = tap0;
    load_out   = 1'b0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = acc_seek ? ST_SEEK : ST_FIN;
        end
      end
      ST_SEEK: begin
        if (!at_target) begin
          ring_shift = 1'b1;
        end else begin
          state_next = ST_FIN;
          case (op)
            CMD_APPEND: begin
              ring_shift = 1'b1;
              ring_fb    = word;
              count_next = count + 1'b1;
              if (CAP_W'(count) == cap) begin
                cap_next = cap << 1;
              end
            end
            CMD_SET: begin
              ring_shift = 1'b1;
              ring_fb    = word;
            end
            CMD_GET: begin
              ring_shift = 1'b1;
            end
            CMD_ERASE: begin
              state_next = ST_ERASE;
            end
            default: begin
              state_next = ST_FIN;
            end
          endcase
        end
      end
      ST_ERASE: begin
        if (at_last) begin
          count_next = cnt_m1;
          if (CAP_W'(cnt_m1) < (cap >> 1)) begin
            cap_next = cap >> 1;
          end
          state_next = ST_FIN;
        end else begin
          // slot j takes the word of slot j+1
          ring_shift = 1'b1;
          ring_fb    = tap1;
        end
      end
      ST_FIN: begin
        if (!out_valid || out_ready) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // ring position of the word at the tap
  always_comb begin
    head_next = head;
    if (ring_shift) begin
      head_next = (head == AW'(DEPTH - 1)) ? '0 : head + 1'b1;
    end
  end

  always_comb begin
    out_valid_next = out_valid;
    if (load_out) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      cap       <= CAP_W'(INITIAL_CAPACITY);
      head      <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      cap       <= cap_next;
      head      <= head_next;
      out_valid <= out_valid_next;
    end
  end

  // command payload and read capture
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op     <= cmd_t'(cmd);
      word   <= value;
      target <= acc_target;
      err    <= acc_err;
      rd     <= '0;
    end else if (state == ST_SEEK && at_target && op == CMD_GET) begin
      rd <= tap0;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (load_out) begin
      read_value   <= rd;
      size_now     <= count[SIZE_W-1:0];
      capacity_now <= cap[SIZE_W-1:0];
      error        <= err;
    end
  end

  `DASE_ASSERT(a_count_bound, count <= CNT_W'(DEPTH), "entry count exceeds depth")
  `DASE_ASSERT(a_shift_state, ring_shift |-> (state == ST_SEEK || state == ST_ERASE), "idle shift")
  `DASE_ASSERT(a_head_hold, !ring_shift |=> $stable(head), "ring position moved without rotation")
  `DASE_ASSERT(a_result_src, $rose(out_valid) |-> $past(state == ST_FIN), "result raised outside finish")
  `DASE_ASSERT_RST(a_reset_vals, rst |=> (count == '0 && !out_valid), "bad state after reset")
  `DASE_ASSERT_RST(a_reset_cap, rst |=> cap == CAP_W'(INITIAL_CAPACITY), "bad capacity after reset")

endmodule

@@ rtl/dynamic_array_shift_erase_unit.sv @@
// Commands that fail a check, and status, go straight to the finish state; the others first
// rotate the ring until the target slot (an append targets slot size) reaches the tap, and an
// erase then moves each word above the index down one slot. One command at a time: input is
// ready again as the result appears; finish waits while an earlier result is still unaccepted.
// Reset: size 0, capacity INITIAL_CAPACITY, result channel empty; ring contents not cleared.
// Top level: circulating ring of word cells plus the command sequencer.
module dynamic_array_shift_erase_unit
  import dase_pkg::*;
#(
  parameter int DEPTH            = 1024,
  parameter int INITIAL_CAPACITY = 10
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [CMD_W-1:0]         cmd,
  input  logic [IDX_W-1:0]         index,
  input  logic signed [WORD_W-1:0] value,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [WORD_W-1:0] read_value,
  output logic [SIZE_W-1:0]        size_now,
  output logic [SIZE_W-1:0]        capacity_now,
  output logic [ERR_W-1:0]         error
);

  logic [WORD_W-1:0] q [DEPTH];
  logic              ring_shift;
  logic [WORD_W-1:0] ring_fb;
  logic [WORD_W-1:0] rd_word;

  assign read_value = rd_word;

  // ring: each cell takes its upper neighbor, the top cell takes the feedback word
  for (genvar k = 0; k < DEPTH; k++) begin : g_ring
    if (k == DEPTH - 1) begin : g_top
      dase_cell u_cell (
        .clk   (clk),
        .shift (ring_shift),
        .d     (ring_fb),
        .q     (q[k])
      );
    end else begin : g_mid
      dase_cell u_cell (
        .clk   (clk),
        .shift (ring_shift),
        .d     (q[k+1]),
        .q     (q[k])
      );
    end
  end

  dase_ctrl #(
    .DEPTH            (DEPTH),
    .INITIAL_CAPACITY (INITIAL_CAPACITY)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .cmd          (cmd),
    .index        (index),
    .value        (value),
    .tap0         (q[0]),
    .tap1         (q[1]),
    .ring_shift   (ring_shift),
    .ring_fb      (ring_fb),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .read_value   (rd_word),
    .size_now     (size_now),
    .capacity_now (capacity_now),
    .error        (error)
  );

endmodule
